// File: sv/bthin_pkg.sv
package bthin_pkg;

  localparam int DATA_W       = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic RULE_ZHANG_SUEN = 1'b0;
  localparam logic RULE_GUO_HALL   = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_EVAL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

endpackage

// File: sv/bthin_store.sv
module bthin_store #(
  parameter int Depth = 64,
  parameter int Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bthin_rule.sv
module bthin_rule #(
  parameter int Width = 64
) (
  input  logic [Width-1:0] up_i,
  input  logic [Width-1:0] cur_i,
  input  logic [Width-1:0] low_i,
  input  logic [Width-1:0] interior_i,
  input  logic             sub_i,
  input  logic             rule_i,
  output logic [Width-1:0] mark_o
);
  import bthin_pkg::*;

  function automatic logic del_pix(input logic p2, input logic p3, input logic p4,
                                   input logic p5, input logic p6, input logic p7,
                                   input logic p8, input logic p9, input logic sub,
                                   input logic rule);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic [3:0] n1;
    logic [3:0] n2;
    logic [3:0] n;
    logic       m1;
    logic       m2;
    logic       m;
    logic       res;
    a  = 4'(!p2 && p3) + 4'(!p3 && p4) + 4'(!p4 && p5) + 4'(!p5 && p6)
       + 4'(!p6 && p7) + 4'(!p7 && p8) + 4'(!p8 && p9) + 4'(!p9 && p2);
    b  = 4'(p2) + 4'(p3) + 4'(p4) + 4'(p5) + 4'(p6) + 4'(p7) + 4'(p8) + 4'(p9);
    m1 = sub ? (p2 & p4 & p8) : (p2 & p4 & p6);
    m2 = sub ? (p2 & p6 & p8) : (p4 & p6 & p8);
    c  = 4'(!p2 & (p3 | p4)) + 4'(!p4 & (p5 | p6))
       + 4'(!p6 & (p7 | p8)) + 4'(!p8 & (p9 | p2));
    n1 = 4'(p9 | p2) + 4'(p3 | p4) + 4'(p5 | p6) + 4'(p7 | p8);
    n2 = 4'(p2 | p3) + 4'(p4 | p5) + 4'(p6 | p7) + 4'(p8 | p9);
    n  = (n1 < n2) ? n1 : n2;
    m  = sub ? ((p2 | p3 | !p5) & p4) : ((p6 | p7 | !p9) & p8);
    if (rule == RULE_ZHANG_SUEN) begin
      res = (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6) && !m1 && !m2;
    end else begin
      res = (c == 4'd1) && (n >= 4'd2) && (n <= 4'd3) && !m;
    end
    return res;
  endfunction

  always_comb begin
    mark_o = '0;
    for (int j = 1; j < Width - 1; j++) begin
      mark_o[j] = cur_i[j] && interior_i[j]
                  && del_pix(up_i[j], up_i[j+1], cur_i[j+1], low_i[j+1],
                             low_i[j], low_i[j-1], cur_i[j-1], up_i[j-1],
                             sub_i, rule_i);
    end
  end

endmodule

// File: sv/binary_image_thinning_top.sv
// Binary image thinning (Zhang-Suen or Guo-Hall). Rows are loaded one item per
// cycle into a row store; the item that completes the configured height starts
// thinning, and in_ready_o stays low until every thinned row has been handed
// to the output register. Each sub-iteration sweeps the interior rows through
// one shared row-wide deletion unit at one row per cycle, fed by the store's
// single read port; a pass is two sub-iterations, and passes repeat until a
// pass clears nothing. Emission then reads each row from the store and loads
// it into the output register. Images narrower or shorter than three skip
// thinning. The store needs no clearing after reset.
module binary_image_thinning_top #(
  parameter int MAX_WIDTH  = bthin_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bthin_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bthin_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bthin_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bthin_pkg::DATA_W-1:0]     row_bits_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bthin_pkg::DATA_W-1:0]     out_row_bits_o,
  output logic                             last_row_o
);
  import bthin_pkg::*;

  localparam int DEPTH = (MAX_HEIGHT < RESULT_LIMIT) ? MAX_HEIGHT : RESULT_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic                  alg_q;
  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         row_q, row_d;
  logic                  sub_q, sub_d;
  logic                  changed_q, changed_d;
  logic [MAX_WIDTH-1:0]  up_q, up_d;
  logic [MAX_WIDTH-1:0]  cur_q, cur_d;
  logic                  out_valid_q;
  logic [MAX_WIDTH-1:0]  out_row_q;
  logic                  last_q;

  logic [CFG_DATA_W-1:0] w_eff;
  logic [CW-1:0]         h_eff;
  logic [MAX_WIDTH-1:0]  mask;
  logic [MAX_WIDTH-1:0]  interior;
  logic [MAX_WIDTH-1:0]  mark;
  logic [MAX_WIDTH-1:0]  rdata;
  logic                  we, re, out_load;
  logic [AW-1:0]         waddr, raddr;
  logic [MAX_WIDTH-1:0]  wdata;
  logic [CW:0]           cnt_inc;
  logic [CW:0]           row_p2;
  logic [CW:0]           row_p1;
  logic                  in_fire;
  logic                  thin_ok;
  logic                  last_sweep_row;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q    <= RULE_ZHANG_SUEN;
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ALGORITHM: alg_q    <= cfg_data_i[0];
        CFG_WIDTH:     width_q  <= cfg_data_i;
        CFG_HEIGHT:    height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = CFG_DATA_W'(1);
    end else if (width_q > CFG_DATA_W'(MAX_WIDTH)) begin
      w_eff = CFG_DATA_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = CW'(1);
    end else if (height_q > CFG_DATA_W'(DEPTH)) begin
      h_eff = CW'(DEPTH);
    end else begin
      h_eff = CW'(height_q);
    end
    for (int j = 0; j < MAX_WIDTH; j++) begin
      mask[j]     = CFG_DATA_W'(j) < w_eff;
      interior[j] = (j >= 1) && (CFG_DATA_W'(j + 1) < w_eff);
    end
  end

  bthin_store #(
    .Depth (DEPTH),
    .Width (MAX_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bthin_rule #(
    .Width (MAX_WIDTH)
  ) u_rule (
    .up_i       (up_q),
    .cur_i      (cur_q),
    .low_i      (rdata),
    .interior_i (interior),
    .sub_i      (sub_q),
    .rule_i     (alg_q),
    .mark_o     (mark)
  );

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_fire        = in_valid_i && in_ready_o;
  assign cnt_inc        = {1'b0, cnt_q} + (CW+1)'(1);
  assign row_p1         = {1'b0, row_q} + (CW+1)'(1);
  assign row_p2         = {1'b0, row_q} + (CW+1)'(2);
  assign thin_ok        = (w_eff >= CFG_DATA_W'(3)) && (h_eff >= CW'(3));
  assign last_sweep_row = (row_p2 == {1'b0, h_eff});

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    row_d     = row_q;
    sub_d     = sub_q;
    changed_d = changed_q;
    up_d      = up_q;
    cur_d     = cur_q;
    we        = 1'b0;
    waddr     = row_q[AW-1:0];
    wdata     = cur_q & ~mark;
    re        = 1'b0;
    raddr     = row_q[AW-1:0];
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          we    = 1'b1;
          waddr = cnt_q[AW-1:0];
          wdata = row_bits_i[MAX_WIDTH-1:0] & mask;
          if (cnt_inc >= {1'b0, h_eff}) begin
            cnt_d     = '0;
            row_d     = '0;
            sub_d     = 1'b0;
            changed_d = 1'b0;
            state_d   = thin_ok ? ST_RD0 : ST_EMIT_RD;
          end else begin
            cnt_d = cnt_inc[CW-1:0];
          end
        end
      end
      ST_RD0: begin
        re      = 1'b1;
        raddr   = AW'(0);
        state_d = ST_RD1;
      end
      ST_RD1: begin
        re      = 1'b1;
        raddr   = AW'(1);
        up_d    = rdata;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        re      = 1'b1;
        raddr   = AW'(2);
        cur_d   = rdata;
        row_d   = CW'(1);
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        we    = 1'b1;
        up_d  = cur_q;
        cur_d = rdata;
        if (mark != '0) begin
          changed_d = 1'b1;
        end
        if (row_p2 < {1'b0, h_eff}) begin
          re    = 1'b1;
          raddr = row_p2[AW-1:0];
        end
        if (last_sweep_row) begin
          if (!sub_q) begin
            sub_d   = 1'b1;
            state_d = ST_RD0;
          end else if (changed_q || (mark != '0)) begin
            sub_d     = 1'b0;
            changed_d = 1'b0;
            state_d   = ST_RD0;
          end else begin
            sub_d   = 1'b0;
            row_d   = '0;
            state_d = ST_EMIT_RD;
          end
        end else begin
          row_d = row_p1[CW-1:0];
        end
      end
      ST_EMIT_RD: begin
        if (!out_valid_q || out_ready_i) begin
          re      = 1'b1;
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_load = 1'b1;
        if (row_p1 == {1'b0, h_eff}) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end else begin
          row_d   = row_p1[CW-1:0];
          state_d = ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      row_q     <= '0;
      sub_q     <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      sub_q     <= sub_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q <= rdata & mask;
      last_q    <= (row_p1 == {1'b0, h_eff});
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_bits_o = DATA_W'(out_row_q);
  assign last_row_o     = last_q;

endmodule

// File: tb/binary_image_thinning_top_tb.sv
`timescale 1ns / 1ps

module binary_image_thinning_top_tb;
  import bthin_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_ROWS   = 300;
  localparam int MAX_PRINTS    = 40;

  localparam int STYLE_NOISE  = 0;
  localparam int STYLE_SPARSE = 1;
  localparam int STYLE_BLOB   = 2;
  localparam int STYLE_HOLED  = 3;
  localparam int STYLE_FULL   = 4;

  typedef struct packed {
    logic [DATA_W-1:0] bits;
    logic              last;
  } thinned_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [DATA_W-1:0]     row_bits_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [DATA_W-1:0]     out_row_bits_o;
  logic                  last_row_o;

  binary_image_thinning_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .row_bits_i     (row_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_row_bits_o (out_row_bits_o),
    .last_row_o     (last_row_o)
  );

  // shadow of the block
  logic                  thin_rule;
  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic [DATA_W-1:0]     row_store_model [RESULT_LIMIT];
  int                    loaded_rows;

  thinned_row_t          expected_rows [$];
  thinned_row_t          want;
  logic [DATA_W-1:0]     pattern_rows [RESULT_LIMIT];

  int  error_count;
  int  rows_sent;
  int  rows_checked;
  int  zs_images;
  int  gh_images;
  bit  steady_flow;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_width();
    int w;
    w = width_q;
    if (w == 0) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    if (w > DATA_W) w = DATA_W;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_q;
    if (h == 0) h = 1;
    if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
    if (h > RESULT_LIMIT) h = RESULT_LIMIT;
    return h;
  endfunction

  function automatic logic [DATA_W-1:0] width_mask(int w);
    if (w >= DATA_W) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // nb[0..7] = p2..p9, clockwise from the pixel above
  function automatic bit pixel_removable(logic [7:0] nb, int sub, logic rule_sel);
    int   q, trans, cnt, c, n1, n2, nmin;
    logic p2, p3, p4, p5, p6, p7, p8, p9;
    logic blk1, blk2, blk;
    {p9, p8, p7, p6, p5, p4, p3, p2} = nb;
    if (rule_sel == RULE_ZHANG_SUEN) begin
      trans = 0;
      for (q = 0; q < 8; q++)
        if (!nb[q] && nb[(q + 1) % 8]) trans++;
      cnt  = $countones(nb);
      blk1 = (sub == 0) ? (p2 & p4 & p6) : (p2 & p4 & p8);
      blk2 = (sub == 0) ? (p4 & p6 & p8) : (p2 & p6 & p8);
      return trans == 1 && cnt >= 2 && cnt <= 6 && !blk1 && !blk2;
    end
    c = 0;
    if (!p2 && (p3 || p4)) c++;
    if (!p4 && (p5 || p6)) c++;
    if (!p6 && (p7 || p8)) c++;
    if (!p8 && (p9 || p2)) c++;
    n1 = int'(p9 | p2) + int'(p3 | p4) + int'(p5 | p6) + int'(p7 | p8);
    n2 = int'(p2 | p3) + int'(p4 | p5) + int'(p6 | p7) + int'(p8 | p9);
    nmin = (n1 < n2) ? n1 : n2;
    blk = (sub == 0) ? ((p6 | p7 | !p9) & p8) : ((p2 | p3 | !p5) & p4);
    return c == 1 && nmin >= 2 && nmin <= 3 && !blk;
  endfunction

  // one sub-iteration; neighbors come from the image as it stood at its start
  function automatic bit sweep_interior(int w, int h, int sub);
    logic [DATA_W-1:0] above, cur, below, clear_bits;
    logic [7:0]        nb;
    bit                any;
    int                i, j;
    any   = 1'b0;
    above = row_store_model[0];
    for (i = 1; i < h - 1; i++) begin
      cur        = row_store_model[i];
      below      = row_store_model[i + 1];
      clear_bits = '0;
      for (j = 1; j < w - 1; j++) begin
        if (cur[j]) begin
          nb = {above[j-1], cur[j-1], below[j-1], below[j],
                below[j+1], cur[j+1], above[j+1], above[j]};
          if (pixel_removable(nb, sub, thin_rule)) clear_bits[j] = 1'b1;
        end
      end
      if (clear_bits != '0) any = 1'b1;
      row_store_model[i] = cur & ~clear_bits;
      above = cur;
    end
    return any;
  endfunction

  function automatic void thin_store(int w, int h);
    bit changed;
    if (w < 3 || h < 3) return;
    do begin
      changed = 1'b0;
      if (sweep_interior(w, h, 0)) changed = 1'b1;
      if (sweep_interior(w, h, 1)) changed = 1'b1;
    end while (changed);
  endfunction

  function automatic void accept_into_model(logic [DATA_W-1:0] r);
    int                w, h, k;
    logic [DATA_W-1:0] mask;
    thinned_row_t      e;
    w    = eff_width();
    h    = eff_height();
    mask = width_mask(w);
    if (loaded_rows < RESULT_LIMIT) row_store_model[loaded_rows] = r & mask;
    loaded_rows++;
    if (loaded_rows < h) return;
    thin_store(w, h);
    for (k = 0; k < h; k++) begin
      e.bits = row_store_model[k] & mask;
      e.last = (k == h - 1);
      expected_rows.push_back(e);
    end
    loaded_rows = 0;
    if (thin_rule == RULE_GUO_HALL) gh_images++;
    else zs_images++;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
    if (error_count < MAX_PRINTS)
      $display("%0t MISMATCH %s: got %h want %h", $time, what, got, exp_val);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      rows_checked++;
      if (expected_rows.size() == 0) begin
        report_mismatch("row with nothing pending", out_row_bits_o, '0);
      end else begin
        want = expected_rows.pop_front();
        if (out_row_bits_o !== want.bits)
          report_mismatch("out_row_bits", out_row_bits_o, want.bits);
        if (last_row_o !== want.last)
          report_mismatch("last_row", 64'(last_row_o), 64'(want.last));
      end
    end
  end

  initial begin : ready_driver
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady_flow && $urandom_range(0, 3) == 0) hold = gap_len();
      end
    end
  end

  task automatic send_row(input logic [DATA_W-1:0] r);
    int gap;
    gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    row_bits_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rows_sent++;
    accept_into_model(r);
  endtask

  // hold input, let every pending row drain, then give the block time to settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ALGORITHM: thin_rule = val[0];
      CFG_WIDTH:     width_q   = val;
      CFG_HEIGHT:    height_q  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_rule(input logic rule_sel);
    logic [CFG_DATA_W-1:0] val;
    val    = CFG_DATA_W'($urandom_range(0, 127));
    val[0] = rule_sel;
    write_reg(CFG_ALGORITHM, val);
  endtask

  task automatic pick_geometry(input bit full_size);
    logic [CFG_DATA_W-1:0] wv, hv;
    if (full_size) begin
      wv = $urandom_range(0, 1) ? 7'd64 : 7'd127;
      hv = $urandom_range(0, 1) ? 7'd64 : 7'd127;
    end else begin
      case ($urandom_range(0, 9))
        0:       wv = CFG_DATA_W'($urandom_range(0, 2));
        1:       wv = CFG_DATA_W'($urandom_range(65, 127));
        2, 3:    wv = CFG_DATA_W'($urandom_range(56, 64));
        default: wv = CFG_DATA_W'($urandom_range(3, 40));
      endcase
      case ($urandom_range(0, 9))
        0:       hv = CFG_DATA_W'($urandom_range(0, 2));
        1:       hv = CFG_DATA_W'($urandom_range(11, 20));
        default: hv = CFG_DATA_W'($urandom_range(3, 10));
      endcase
    end
    write_reg(CFG_WIDTH, wv);
    write_reg(CFG_HEIGHT, hv);
  endtask

  function automatic void build_pattern(int w, int h, int style);
    int                i, n, b, r0, r1, c0, c1;
    logic [DATA_W-1:0] cols;
    for (i = 0; i < RESULT_LIMIT; i++) pattern_rows[i] = '0;
    case (style)
      STYLE_NOISE:  for (i = 0; i < h; i++) pattern_rows[i] = rand64();
      STYLE_SPARSE: for (i = 0; i < h; i++) pattern_rows[i] = rand64() & rand64();
      STYLE_FULL:   for (i = 0; i < h; i++) pattern_rows[i] = '1;
      default: begin
        n = $urandom_range(1, 3);
        for (b = 0; b < n; b++) begin
          r0   = $urandom_range(0, h - 1);
          r1   = $urandom_range(r0, h - 1);
          c0   = $urandom_range(0, w - 1);
          c1   = $urandom_range(c0, w - 1);
          cols = ((64'd1 << (c1 - c0 + 1)) - 64'd1) << c0;
          for (i = r0; i <= r1; i++) pattern_rows[i] |= cols;
        end
        if (style == STYLE_HOLED)
          for (i = 0; i < h; i++) pattern_rows[i] &= (rand64() | rand64() | rand64());
      end
    endcase
    if ($urandom_range(0, 1) == 0)
      for (i = 0; i < h; i++) pattern_rows[i] |= rand64() & ~width_mask(w);
  endfunction

  task automatic test_border_and_masking();
    // 3x3 of ones: only the center is interior and it has eight neighbors
    write_reg(CFG_WIDTH, 7'd3);
    write_reg(CFG_HEIGHT, 7'd3);
    send_row('1);
    send_row('1);
    send_row(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_degenerate_sizes();
    write_reg(CFG_WIDTH, 7'd0);
    write_reg(CFG_HEIGHT, 7'd0);
    send_row('1);
    write_reg(CFG_WIDTH, 7'd127);
    write_reg(CFG_HEIGHT, 7'd2);
    send_row('1);
    send_row('0);
  endtask

  task automatic test_both_rules();
    write_reg(CFG_WIDTH, 7'd5);
    write_reg(CFG_HEIGHT, 7'd5);
    write_reg(CFG_ALGORITHM, {6'd0, RULE_GUO_HALL});
    write_reg(CFG_SPARE, 7'h7F);
    send_row(64'h0);
    send_row(64'hF000_0000_0000_000E);
    send_row(64'h0E);
    send_row(64'h0E);
    send_row(64'h0);
    write_reg(CFG_ALGORITHM, {6'h2A, RULE_ZHANG_SUEN});
    send_row(64'h0);
    send_row(64'h0E);
    send_row(64'h0E);
    send_row(64'h8000_0000_0000_000E);
    send_row(64'h0);
  endtask

  task automatic test_empty_image();
    write_reg(CFG_WIDTH, 7'd4);
    write_reg(CFG_HEIGHT, 7'd3);
    send_row('0);
    send_row('0);
    send_row('0);
  endtask

  task automatic test_reconfig_while_loading();
    write_reg(CFG_WIDTH, 7'd8);
    write_reg(CFG_HEIGHT, 7'd5);
    send_row(64'h7E);
    send_row(64'h7E);
    write_reg(CFG_HEIGHT, 7'd3);
    send_row(64'h7E);
    write_reg(CFG_HEIGHT, 7'd6);
    send_row(64'hFF);
    send_row(64'h3C);
    send_row(64'h3C);
    send_row(64'hFF);
    // counter already past the new height
    write_reg(CFG_HEIGHT, 7'd2);
    send_row(64'h5A);
  endtask

  task automatic test_random_images();
    int  img_idx, w, h, first, n, k, style, start_rows;
    bit  full_size;
    img_idx    = 0;
    start_rows = rows_sent;
    while (rows_sent - start_rows < RANDOM_ROWS) begin
      full_size = (img_idx == 4 || img_idx == 18);
      if (full_size || (loaded_rows == 0 && $urandom_range(0, 2) == 0)) begin
        write_rule($urandom_range(0, 1));
        pick_geometry(full_size);
      end
      steady_flow = ($urandom_range(0, 4) == 0);
      w     = eff_width();
      h     = eff_height();
      style = full_size ? STYLE_BLOB : $urandom_range(STYLE_NOISE, STYLE_FULL);
      build_pattern(w, h, style);
      first = loaded_rows;
      if (first >= h) begin
        send_row(rand64());
      end else if (h - first >= 2 && $urandom_range(0, 11) == 0) begin
        // cut the image short and change the geometry mid-load
        n = $urandom_range(1, h - first - 1);
        for (k = 0; k < n; k++) send_row(pattern_rows[first + k]);
        pick_geometry(1'b0);
      end else begin
        for (k = first; k < h; k++) send_row(pattern_rows[k]);
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
      img_idx++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    row_bits_i  = '0;
    steady_flow = 1'b0;
    thin_rule   = RULE_ZHANG_SUEN;
    width_q     = RESET_WIDTH;
    height_q    = RESET_HEIGHT;
    loaded_rows = 0;
    for (int i = 0; i < RESULT_LIMIT; i++) row_store_model[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_border_and_masking();
    test_degenerate_sizes();
    test_both_rules();
    test_empty_image();
    test_reconfig_while_loading();
    test_random_images();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_rows.size() != 0)
      report_mismatch("rows never emitted", 64'(expected_rows.size()), '0);
    $display("images thinned: %0d Zhang-Suen, %0d Guo-Hall; rows in %0d, rows checked %0d",
             zs_images, gh_images, rows_sent, rows_checked);
    $display("geometry from 1x1 to 64x64, out-of-range settings, resizing mid-image");
    if (error_count == 0) begin
      $display("binary_image_thinning_top verification clean");
    end else begin
      $display("binary_image_thinning_top verification failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("binary_image_thinning_top verification failed");
    $finish;
  end

endmodule
